// ----- src/assert_macros.svh -----
// assert_macros.svh
// Assertion shorthands for the training step RTL; the using module must have aclk and
// aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BPTS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BPTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bpts_pkg.sv -----
// bpts_pkg.sv
// Shared types, constants and fixed-point helpers for the training step block.
// No dependencies.
package bpts_pkg;

    localparam int NUM_SAMPLES     = 2;
    localparam int SIGMOID_ENTRIES = 256;

    // sigmoid segments over the 16-bit argument range
    localparam int          SEG_STEP = 65536 / SIGMOID_ENTRIES;
    localparam logic [15:0] SEG_MASK = 16'(65536 - SEG_STEP);
    localparam logic [15:0] SEG_HALF = 16'(SEG_STEP / 2);
    localparam logic [12:0] SIG_ONE  = 13'd4096;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 128;

    typedef logic signed [15:0] q_t;
    typedef logic signed [16:0] mop_t;
    typedef logic [NUM_SAMPLES-1:0] mask_t;

    localparam mask_t ALL_MASK = '1;
    localparam mask_t MASK_ONE = mask_t'(1);

    localparam q_t HID_BIAS_INIT = 16'sd1638;
    localparam q_t HID_W1_INIT   = -16'sd1229;
    localparam q_t HID_W2_INIT   = -16'sd2048;
    localparam q_t OUT_BIAS_INIT = 16'sd819;
    localparam q_t OUT_HW_INIT   = -16'sd1638;
    localparam q_t OUT_SW_INIT   = 16'sd819;
    localparam logic [11:0] TOL_INIT = 12'd8;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_X1_HW1,
        MUL_X2_HW2,
        MUL_OHW_H,
        MUL_OSW_X2,
        MUL_DSIG_Y,
        MUL_ERR_DSY,
        MUL_DSIG_H,
        MUL_DK_OHW,
        MUL_Q_DSH,
        MUL_DK_H,
        MUL_DK_X2,
        MUL_DZ_X1,
        MUL_DZ_X2
    } mul_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_X1,
        ST_MUL_X2,
        ST_SUM_H,
        ST_SIG_H,
        ST_MUL_OH,
        ST_MUL_OS,
        ST_SUM_Y,
        ST_SIG_Y,
        ST_ERR,
        ST_CHECK,
        ST_DECIDE,
        ST_DK,
        ST_DKW,
        ST_DKO,
        ST_DZ,
        ST_DW1,
        ST_DW2,
        ST_DV1,
        ST_DV2,
        ST_WB,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_hid;
        logic     acc_out;
        logic     sum_z;
        logic     sig_h;
        logic     sig_y;
        logic     err_en;
        logic     chk_en;
        logic     decide;
        logic     dk_en;
        logic     dsh_en;
        logic     dz_en;
        logic     upd_out_a;
        logic     upd_out_b;
        logic     upd_hid_a;
        logic     upd_hid_b;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic go_update;
    } dp_status_t;

    typedef struct packed {
        logic [12:0] net_output;
        q_t          output_error;
        logic        within_tolerance;
        logic        all_learned;
        logic        weights_updated;
        q_t          out_bias;
        q_t          out_hidden_weight;
        q_t          out_skip_weight;
        q_t          hid_bias;
        q_t          hid_weight_one;
        q_t          hid_weight_two;
    } dp_result_t;

    function automatic q_t sat16(input logic signed [23:0] v);
        q_t r;
        if (v > 24'sd32767) begin
            r = 16'sd32767;
        end else if (v < -24'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    // sigmoid sampled every 0.25 on [0, 8], unsigned Q0.12
    function automatic logic [11:0] sig_pos(input logic [5:0] i);
        logic [11:0] r;
        case (i)
            6'd0:  r = 12'd2048;
            6'd1:  r = 12'd2303;
            6'd2:  r = 12'd2550;
            6'd3:  r = 12'd2782;
            6'd4:  r = 12'd2994;
            6'd5:  r = 12'd3184;
            6'd6:  r = 12'd3349;
            6'd7:  r = 12'd3490;
            6'd8:  r = 12'd3608;
            6'd9:  r = 12'd3705;
            6'd10: r = 12'd3785;
            6'd11: r = 12'd3850;
            6'd12: r = 12'd3902;
            6'd13: r = 12'd3943;
            6'd14: r = 12'd3976;
            6'd15: r = 12'd4002;
            6'd16: r = 12'd4022;
            6'd17: r = 12'd4038;
            6'd18: r = 12'd4051;
            6'd19: r = 12'd4061;
            6'd20: r = 12'd4069;
            6'd21: r = 12'd4075;
            6'd22: r = 12'd4079;
            6'd23: r = 12'd4083;
            6'd24: r = 12'd4086;
            6'd25: r = 12'd4088;
            6'd26: r = 12'd4090;
            6'd27: r = 12'd4091;
            6'd28: r = 12'd4092;
            6'd29: r = 12'd4093;
            6'd30: r = 12'd4094;
            6'd31: r = 12'd4094;
            default: r = 12'd4095;
        endcase
        return r;
    endfunction

    // Segment centre is the argument with its low bits replaced by the half step;
    // the curve is interpolated between the quarter-unit samples.
    function automatic logic [12:0] sig_lookup(input q_t z);
        logic [15:0] c;
        logic [15:0] a;
        logic [5:0]  seg;
        logic [9:0]  frac;
        logic [11:0] lo;
        logic [11:0] hi;
        logic [18:0] prod;
        logic [11:0] s;
        c    = (z & SEG_MASK) | SEG_HALF;
        a    = c[15] ? 16'(-c) : c;
        seg  = a[15:10];
        frac = a[9:0];
        lo   = sig_pos(seg);
        hi   = sig_pos(6'(seg + 6'd1));
        prod = 19'(hi - lo) * 19'(frac) + 19'd512;
        s    = lo + 12'(prod[18:10]);
        return c[15] ? 13'(SIG_ONE - 13'(s)) : 13'(s);
    endfunction

endpackage

// ----- src/bpts_qmul.sv -----
// bpts_qmul.sv
// Shared Q4.12 multiplier: registered product, then round half up and saturate.
// Depends on bpts_pkg.
module bpts_qmul (
    input  logic         aclk,
    input  logic         mul_en,
    input  bpts_pkg::mop_t op_a,
    input  bpts_pkg::mop_t op_b,
    output bpts_pkg::q_t   prod_q
);
    import bpts_pkg::*;

    logic signed [33:0] prod_reg;
    logic signed [34:0] rounded;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign rounded = 35'(prod_reg) + 35'sd2048;
    assign prod_q  = sat16(24'(rounded >>> 12));

endmodule

// ----- src/bpts_datapath.sv -----
// bpts_datapath.sv
// Weights, sample marks, forward and update arithmetic around the shared multiplier.
// Depends on bpts_pkg, bpts_qmul and assert_macros.svh.
`include "assert_macros.svh"

module bpts_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bpts_pkg::dp_cmd_t    cmd,
    input  logic                 in_index,
    input  bpts_pkg::q_t         in_one,
    input  bpts_pkg::q_t         in_two,
    input  bpts_pkg::q_t         in_target,
    input  logic                 cfg_we,
    input  logic [11:0]          cfg_tol,
    output bpts_pkg::dp_status_t status,
    output bpts_pkg::dp_result_t result
);
    import bpts_pkg::*;

    q_t          x1_reg, x2_reg, t_reg;
    logic        idx_reg;
    logic signed [16:0] acc_reg;
    q_t          z_reg;
    logic [12:0] h_reg, y_reg;
    q_t          err_reg;
    logic        within_reg;
    q_t          dk_reg, dsh_reg, dz_reg;
    logic        updated_reg;

    q_t          out_bias_reg, out_hw_reg, out_sw_reg;
    q_t          hid_bias_reg, hid_w1_reg, hid_w2_reg;
    mask_t       mask_reg;
    logic        done_reg;
    logic [11:0] tol_reg;

    mop_t        op_a, op_b;
    q_t          q;
    logic [16:0] err_mag;
    mask_t       sel_bit, mask_set;
    logic        idx_ok, active, finish;

    bpts_qmul u_qmul (
        .aclk   (aclk),
        .mul_en (cmd.mul_en),
        .op_a   (op_a),
        .op_b   (op_b),
        .prod_q (q)
    );

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            MUL_NONE: begin
                op_a = '0;
                op_b = '0;
            end
            MUL_X1_HW1: begin
                op_a = 17'(x1_reg);
                op_b = 17'(hid_w1_reg);
            end
            MUL_X2_HW2: begin
                op_a = 17'(x2_reg);
                op_b = 17'(hid_w2_reg);
            end
            MUL_OHW_H: begin
                op_a = 17'(out_hw_reg);
                op_b = mop_t'({4'b0, h_reg});
            end
            MUL_OSW_X2: begin
                op_a = 17'(out_sw_reg);
                op_b = 17'(x2_reg);
            end
            MUL_DSIG_Y: begin
                op_a = mop_t'({4'b0, y_reg});
                op_b = mop_t'({4'b0, 13'(SIG_ONE - y_reg)});
            end
            MUL_ERR_DSY: begin
                op_a = 17'(err_reg);
                op_b = 17'(q);
            end
            MUL_DSIG_H: begin
                op_a = mop_t'({4'b0, h_reg});
                op_b = mop_t'({4'b0, 13'(SIG_ONE - h_reg)});
            end
            MUL_DK_OHW: begin
                op_a = 17'(dk_reg);
                op_b = 17'(out_hw_reg);
            end
            MUL_Q_DSH: begin
                op_a = 17'(q);
                op_b = 17'(dsh_reg);
            end
            MUL_DK_H: begin
                op_a = 17'(dk_reg);
                op_b = mop_t'({4'b0, h_reg});
            end
            MUL_DK_X2: begin
                op_a = 17'(dk_reg);
                op_b = 17'(x2_reg);
            end
            MUL_DZ_X1: begin
                op_a = 17'(dz_reg);
                op_b = 17'(x1_reg);
            end
            MUL_DZ_X2: begin
                op_a = 17'(dz_reg);
                op_b = 17'(x2_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign err_mag = err_reg[15] ? 17'(-(17'(err_reg))) : 17'(err_reg);

    // sample bookkeeping: out-of-range index shifts the mark bit away
    assign idx_ok   = (32'(idx_reg) < NUM_SAMPLES);
    assign sel_bit  = MASK_ONE << idx_reg;
    assign mask_set = mask_reg | sel_bit;
    assign active   = idx_ok && !done_reg && ((mask_reg & sel_bit) == '0);
    assign finish   = within_reg && (mask_set == ALL_MASK);

    assign status.go_update = active && !finish;

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x1_reg  <= in_one;
            x2_reg  <= in_two;
            t_reg   <= in_target;
            idx_reg <= in_index;
        end
        if (cmd.acc_hid) begin
            acc_reg <= 17'(hid_bias_reg) + 17'(q);
        end
        if (cmd.acc_out) begin
            acc_reg <= 17'(out_bias_reg) + 17'(q);
        end
        if (cmd.sum_z) begin
            z_reg <= sat16(24'(acc_reg) + 24'(q));
        end
        if (cmd.sig_h) begin
            h_reg <= sig_lookup(z_reg);
        end
        if (cmd.sig_y) begin
            y_reg <= sig_lookup(z_reg);
        end
        if (cmd.err_en) begin
            err_reg <= sat16(24'(t_reg) - 24'($signed({1'b0, y_reg})));
        end
        if (cmd.chk_en) begin
            within_reg <= (err_mag <= {5'b0, tol_reg});
        end
        if (cmd.dk_en) begin
            dk_reg <= q;
        end
        if (cmd.dsh_en) begin
            dsh_reg <= q;
        end
        if (cmd.dz_en) begin
            dz_reg <= q;
        end
        if (cmd.load_in) begin
            updated_reg <= 1'b0;
        end else if (cmd.upd_hid_b) begin
            updated_reg <= 1'b1;
        end
    end

    // trained state and tolerance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_bias_reg <= OUT_BIAS_INIT;
            out_hw_reg   <= OUT_HW_INIT;
            out_sw_reg   <= OUT_SW_INIT;
            hid_bias_reg <= HID_BIAS_INIT;
            hid_w1_reg   <= HID_W1_INIT;
            hid_w2_reg   <= HID_W2_INIT;
            mask_reg     <= '0;
            done_reg     <= 1'b0;
            tol_reg      <= TOL_INIT;
        end else begin
            if (cfg_we) begin
                tol_reg <= cfg_tol;
            end
            if (cmd.decide && active && within_reg) begin
                mask_reg <= mask_set;
                if (finish) begin
                    done_reg <= 1'b1;
                end
            end
            if (cmd.upd_out_a) begin
                out_bias_reg <= sat16(24'(out_bias_reg) + 24'(dk_reg));
                out_hw_reg   <= sat16(24'(out_hw_reg) + 24'(q));
            end
            if (cmd.upd_out_b) begin
                out_sw_reg <= sat16(24'(out_sw_reg) + 24'(q));
            end
            if (cmd.upd_hid_a) begin
                hid_bias_reg <= sat16(24'(hid_bias_reg) + 24'(dz_reg));
                hid_w1_reg   <= sat16(24'(hid_w1_reg) + 24'(q));
            end
            if (cmd.upd_hid_b) begin
                hid_w2_reg <= sat16(24'(hid_w2_reg) + 24'(q));
            end
        end
    end

    assign result.net_output        = y_reg;
    assign result.output_error      = err_reg;
    assign result.within_tolerance  = within_reg;
    assign result.all_learned       = done_reg;
    assign result.weights_updated   = updated_reg;
    assign result.out_bias          = out_bias_reg;
    assign result.out_hidden_weight = out_hw_reg;
    assign result.out_skip_weight   = out_sw_reg;
    assign result.hid_bias          = hid_bias_reg;
    assign result.hid_weight_one    = hid_w1_reg;
    assign result.hid_weight_two    = hid_w2_reg;

    `BPTS_ASSERT_IMPL(a_done_mask, done_reg, mask_reg == ALL_MASK, "done without every sample marked")
    `BPTS_ASSERT_NEXT(a_frozen, done_reg, $stable(out_bias_reg) && $stable(hid_bias_reg), "weights moved after training finished")

endmodule

// ----- src/bpts_ctrl.sv -----
// bpts_ctrl.sv
// Step sequencer: walks the forward pass, the tolerance decision and the update.
// Depends on bpts_pkg.
module bpts_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 out_free,
    input  bpts_pkg::dp_status_t status,
    output bpts_pkg::dp_cmd_t    cmd
);
    import bpts_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_MUL_X1;
            ST_MUL_X1: state_next = ST_MUL_X2;
            ST_MUL_X2: state_next = ST_SUM_H;
            ST_SUM_H:  state_next = ST_SIG_H;
            ST_SIG_H:  state_next = ST_MUL_OH;
            ST_MUL_OH: state_next = ST_MUL_OS;
            ST_MUL_OS: state_next = ST_SUM_Y;
            ST_SUM_Y:  state_next = ST_SIG_Y;
            ST_SIG_Y:  state_next = ST_ERR;
            ST_ERR:    state_next = ST_CHECK;
            ST_CHECK:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = status.go_update ? ST_DK : ST_OUT;
            ST_DK:     state_next = ST_DKW;
            ST_DKW:    state_next = ST_DKO;
            ST_DKO:    state_next = ST_DZ;
            ST_DZ:     state_next = ST_DW1;
            ST_DW1:    state_next = ST_DW2;
            ST_DW2:    state_next = ST_DV1;
            ST_DV1:    state_next = ST_DV2;
            ST_DV2:    state_next = ST_WB;
            ST_WB:     state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MUL_NONE;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_MUL_X1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X1_HW1;
            end
            ST_MUL_X2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X2_HW2;
                cmd.acc_hid = 1'b1;
            end
            ST_SUM_H:  cmd.sum_z = 1'b1;
            ST_SIG_H:  cmd.sig_h = 1'b1;
            ST_MUL_OH: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_OHW_H;
            end
            ST_MUL_OS: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_OSW_X2;
                cmd.acc_out = 1'b1;
            end
            ST_SUM_Y:  cmd.sum_z  = 1'b1;
            ST_SIG_Y:  cmd.sig_y  = 1'b1;
            ST_ERR:    cmd.err_en = 1'b1;
            ST_CHECK: begin
                cmd.chk_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DSIG_Y;
            end
            ST_DECIDE: cmd.decide = 1'b1;
            ST_DK: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ERR_DSY;
            end
            ST_DKW: begin
                cmd.dk_en   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DSIG_H;
            end
            ST_DKO: begin
                cmd.dsh_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DK_OHW;
            end
            ST_DZ: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Q_DSH;
            end
            ST_DW1: begin
                cmd.dz_en   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DK_H;
            end
            ST_DW2: begin
                cmd.upd_out_a = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_DK_X2;
            end
            ST_DV1: begin
                cmd.upd_out_b = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_DZ_X1;
            end
            ST_DV2: begin
                cmd.upd_hid_a = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_DZ_X2;
            end
            ST_WB:  cmd.upd_hid_b = 1'b1;
            ST_OUT: cmd.out_load  = out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/backprop_training_step_unit.sv -----
// backprop_training_step_unit.sv
// Top level of the online sigmoid-network training step: ports, output register.
// Depends on bpts_pkg, bpts_ctrl, bpts_datapath and assert_macros.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  s_      | in        | s_tvalid / s_tready  | s_tdata: samples, s_tuser: index
//  m_      | out       | m_tvalid / m_tready  | m_tdata: output, error, flags, weights
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_data: error tolerance
//
// A word runs from acceptance to result through the forward pass and the tolerance
// decision, and through the update too when the weights change; the sequence is set by
// the single shared multiplier, which steps through the chain of dependent products.
// Reset loads the initial weights and a tolerance of 8 and clears the sample marks.
// A result waits in the output register; the next word is accepted meanwhile and only
// its final step stalls while that register is still full.
`include "assert_macros.svh"

module backprop_training_step_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] input_one, [31:16] input_two, [47:32] target_value
    input  logic [bpts_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] sample_index
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [12:0] net_output, [28:13] output_error, [29] within_tolerance,
    // [30] all_learned, [31] weights_updated, [47:32] out_bias,
    // [63:48] out_hidden_weight, [79:64] out_skip_weight, [95:80] hid_bias,
    // [111:96] hid_weight_one, [127:112] hid_weight_two
    output logic [bpts_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [11:0]                        cfg_data
);
    import bpts_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    dp_result_t result;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 out_free;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    bpts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    bpts_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_index  (s_tuser[0]),
        .in_one    (q_t'(s_tdata[15:0])),
        .in_two    (q_t'(s_tdata[31:16])),
        .in_target (q_t'(s_tdata[47:32])),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_tol   (cfg_data),
        .status    (status),
        .result    (result)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {result.hid_weight_two, result.hid_weight_one, result.hid_bias,
                            result.out_skip_weight, result.out_hidden_weight,
                            result.out_bias, result.weights_updated, result.all_learned,
                            result.within_tolerance, result.output_error,
                            result.net_output};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BPTS_ASSERT_IMPL(a_no_overrun, cmd.out_load, !m_tvalid_reg || m_tready, "output overrun")

endmodule
